@@ rtl/chgs_pkg.sv @@
// Shared types and constants for the convex hull core.
// No dependencies; imported by every module of the block except chgs_ram.
`timescale 1ns / 1ps
package chgs_pkg;
    localparam int MAX_POINTS = 64;
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = IDX_W + 1;
    localparam int COORD_W = 31;
    localparam int PT_W = 2 * COORD_W;
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = 2 * DIFF_W;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } pt_t;

    // One queue entry between the front and the back part.
    typedef struct packed {
        pt_t  pt;
        logic keep;
        logic last;
    } cmd_t;
endpackage

@@ rtl/chgs_ram.sv @@
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module chgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/chgs_front.sv @@
// Front part: accepts points, counts them and marks overflow.
// Depends on chgs_pkg; feeds a two-entry queue to the back part.
`timescale 1ns / 1ps
module chgs_front
    import chgs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        s_tlast,
    output logic        q_valid,
    input  logic        q_ready,
    output cmd_t        q_cmd
);
    cmd_t q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic rd_reg, wr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic push, pop;
    cmd_t cmd;

    assign s_tready = (cnt_reg != 2'd2);
    assign push = s_tvalid && s_tready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_cmd = q_reg[rd_reg];

    always_comb
    begin
        cmd.pt.x = s_tdata[COORD_W-1:0];
        cmd.pt.y = s_tdata[2*COORD_W-1:COORD_W];
        cmd.keep = (count_reg < CNT_W'(MAX_POINTS));
        cmd.last = s_tlast;
        count_next = count_reg;
        if (push)
        begin
            count_next = s_tlast ? '0 : (cmd.keep ? count_reg + 1'b1 : count_reg);
        end
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            count_reg <= count_next;
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS)) else $error("point count beyond capacity");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("queue overrun");
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        push && s_tlast |=> count_reg == '0) else $error("count not cleared");
`endif
endmodule

@@ rtl/chgs_back.sv @@
// Back part: stores points, finds pivot, insertion-sorts, scans and emits.
// Depends on chgs_pkg and chgs_ram.
`timescale 1ns / 1ps
module chgs_back
    import chgs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  cmd_t        q_cmd,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);
    typedef enum logic [15:0] {
        S_LOAD   = 16'h0001,
        S_PIVR   = 16'h0002,
        S_PIVW   = 16'h0004,
        S_SWPR   = 16'h0008,
        S_SWPW   = 16'h0010,
        S_INSR   = 16'h0020,
        S_INSW   = 16'h0040,
        S_CMPR   = 16'h0080,
        S_CMPM   = 16'h0100,
        S_CMPD   = 16'h0200,
        S_SCNR   = 16'h0400,
        S_SCNW   = 16'h0800,
        S_SCNM   = 16'h1000,
        S_SCND   = 16'h2000,
        S_OUTR   = 16'h4000,
        S_OUTW   = 16'h8000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] n_reg, n_next, i_reg, i_next, j_reg, j_next, s_reg, s_next;
    logic [CNT_W-1:0] best_reg, best_next;
    logic ovf_reg, ovf_next;
    pt_t piv_reg, piv_next, t_reg, t_next, b_reg, b_next, a_reg, a_next;
    logic we;
    logic [IDX_W-1:0] waddr, raddr;
    pt_t wdata, rdata;
    logic signed [DIFF_W-1:0] d0, d1, d2, d3;
    logic signed [PROD_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [PROD_W:0] lhs, rhs;
    logic mul_sel_reg, mul_sel_next;
    logic psel_reg;
    logic [1:0] ph_reg, ph_next;
    logic ovalid_reg, ovalid_next, olast_reg, olast_next;
    pt_t opt_reg, opt_next;

    chgs_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_store (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata));

    // Shared difference/multiply unit: cross products or squares, chosen by mul_sel_reg.
    always_comb
    begin
        if (!mul_sel_reg)
        begin
            // cross3(o=b, pv, a) = (b-pv)x(b-a)
            d0 = DIFF_W'(b_reg.x) - DIFF_W'(piv_reg.x);
            d1 = DIFF_W'(b_reg.y) - DIFF_W'(a_reg.y);
            d2 = DIFF_W'(b_reg.y) - DIFF_W'(piv_reg.y);
            d3 = DIFF_W'(b_reg.x) - DIFF_W'(a_reg.x);
        end
        else
        begin
            d0 = DIFF_W'(piv_reg.x) - DIFF_W'(a_reg.x);
            d1 = DIFF_W'(piv_reg.y) - DIFF_W'(a_reg.y);
            d2 = DIFF_W'(piv_reg.x) - DIFF_W'(b_reg.x);
            d3 = DIFF_W'(piv_reg.y) - DIFF_W'(b_reg.y);
        end
    end

    always_ff @(posedge clk)
    begin
        if (!mul_sel_reg)
        begin
            p0_reg <= d0 * d1;
            p1_reg <= d2 * d3;
        end
        else
        begin
            p0_reg <= d0 * d0;
            p1_reg <= d1 * d1;
            p2_reg <= d2 * d2;
            p3_reg <= d3 * d3;
        end
    end

    // psel_reg tells what the product registers hold: cross terms or squares.
    assign lhs = psel_reg ? (PROD_W+1)'(p0_reg) + (PROD_W+1)'(p1_reg)
                          : (PROD_W+1)'(p0_reg);
    assign rhs = psel_reg ? (PROD_W+1)'(p2_reg) + (PROD_W+1)'(p3_reg)
                          : (PROD_W+1)'(p1_reg);

    assign m_tvalid = ovalid_reg;
    assign m_tdata = {2'b00, opt_reg.y, opt_reg.x};
    assign m_tuser = {ovf_reg, olast_reg};
    assign m_tlast = olast_reg;
    assign q_ready = (state_reg == S_LOAD) && !ovalid_reg;

    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg; i_next = i_reg; j_next = j_reg; s_next = s_reg;
        best_next = best_reg; ovf_next = ovf_reg;
        piv_next = piv_reg; t_next = t_reg; b_next = b_reg; a_next = a_reg;
        mul_sel_next = mul_sel_reg; ph_next = ph_reg;
        ovalid_next = ovalid_reg && !m_tready;
        olast_next = olast_reg; opt_next = opt_reg;
        we = 1'b0; waddr = n_reg[IDX_W-1:0]; wdata = q_cmd.pt;
        raddr = i_reg[IDX_W-1:0];
        case (state_reg)
            S_LOAD:
            begin
                if (q_valid && !ovalid_reg)
                begin
                    we = q_cmd.keep;
                    n_next = q_cmd.keep ? n_reg + 1'b1 : n_reg;
                    ovf_next = ovf_reg | !q_cmd.keep;
                    if (q_cmd.last)
                    begin
                        i_next = '0; best_next = '0;
                        state_next = S_PIVR;
                    end
                end
            end
            S_PIVR:
            begin
                i_next = i_reg + 1'b1;
                state_next = S_PIVW;
            end
            S_PIVW:
            begin
                // rdata holds point i_reg-1.
                if (i_reg == CNT_W'(1) ||
                    rdata.x < piv_reg.x || (rdata.x == piv_reg.x && rdata.y > piv_reg.y))
                begin
                    piv_next = rdata; best_next = i_reg - 1'b1;
                end
                if (i_reg == n_reg)
                begin
                    i_next = '0;
                    state_next = S_SWPR;
                end
                else
                begin
                    state_next = S_PIVR;
                end
            end
            S_SWPR:
            begin
                raddr = '0;
                state_next = S_SWPW;
            end
            S_SWPW:
            begin
                we = 1'b1; waddr = best_reg[IDX_W-1:0]; wdata = rdata;
                i_next = CNT_W'(1);
                state_next = S_INSR;
            end
            S_INSR:
            begin
                if (i_reg == CNT_W'(1))
                begin
                    we = 1'b1; waddr = '0; wdata = piv_reg;
                    state_next = S_INSR; i_next = CNT_W'(2);
                end
                else if (i_reg >= n_reg)
                begin
                    i_next = '0; s_next = '0;
                    state_next = S_SCNR;
                end
                else
                begin
                    state_next = S_INSW;
                end
            end
            S_INSW:
            begin
                t_next = rdata; a_next = rdata;
                j_next = i_reg;
                raddr = IDX_W'(i_reg - 1'b1);
                state_next = S_CMPR;
            end
            S_CMPR:
            begin
                b_next = rdata; mul_sel_next = 1'b0;
                state_next = S_CMPM;
            end
            S_CMPM:
            begin
                mul_sel_next = 1'b1;
                state_next = S_CMPD;
                ph_next = 2'd0;
            end
            S_CMPD:
            begin
                // Phase 0 sees the cross products; the later phases see the distances.
                if (ph_reg == 2'd0)
                begin
                    ph_next = 2'd1;
                    if (lhs != rhs)
                    begin
                        ph_next = (lhs > rhs) ? 2'd2 : 2'd3;
                    end
                end
                else
                begin
                    if (ph_reg == 2'd2 || (ph_reg == 2'd1 && lhs < rhs))
                    begin
                        we = 1'b1; waddr = j_reg[IDX_W-1:0]; wdata = b_reg;
                        j_next = j_reg - 1'b1;
                        if (j_reg - 1'b1 > CNT_W'(1))
                        begin
                            raddr = IDX_W'(j_reg - 2'd2);
                            state_next = S_CMPR;
                        end
                        else
                        begin
                            // Slot 1 is reached; the moving point goes there next cycle.
                            ph_next = 2'd3;
                        end
                    end
                    else
                    begin
                        we = 1'b1; waddr = j_reg[IDX_W-1:0]; wdata = t_reg;
                        i_next = i_reg + 1'b1;
                        raddr = IDX_W'(i_reg + 1'b1);
                        state_next = S_INSR;
                    end
                end
            end
            S_SCNR:
            begin
                if (i_reg == n_reg)
                begin
                    i_next = '0;
                    state_next = S_OUTR;
                end
                else
                begin
                    raddr = i_reg[IDX_W-1:0];
                    state_next = S_SCNW;
                end
            end
            S_SCNW:
            begin
                // t = a = p; b = stack top (s-1), piv = s-2 kept in registers.
                t_next = rdata; a_next = rdata;
                if (s_reg > '0 && b_reg == rdata)
                begin
                    i_next = i_reg + 1'b1;
                    state_next = S_SCNR;
                end
                else if (s_reg >= CNT_W'(2))
                begin
                    mul_sel_next = 1'b0; ph_next = 2'd0;
                    state_next = S_SCNM;
                end
                else
                begin
                    we = 1'b1; waddr = s_reg[IDX_W-1:0]; wdata = rdata;
                    piv_next = b_reg; b_next = rdata;
                    s_next = s_reg + 1'b1; i_next = i_reg + 1'b1;
                    state_next = S_SCNR;
                end
            end
            S_SCNM:
            begin
                if (ph_reg == 2'd1)
                begin
                    // After a pop the entry below the new top arrives from the store.
                    piv_next = rdata; ph_next = 2'd0;
                end
                else
                begin
                    state_next = S_SCND;
                end
            end
            S_SCND:
            begin
                // cross3(b, piv, t) >= 0 pops.
                if (lhs >= rhs)
                begin
                    if (s_reg == CNT_W'(2))
                    begin
                        // Only the pivot stays below, so the point replaces the top.
                        we = 1'b1; waddr = IDX_W'(1); wdata = t_reg;
                        b_next = t_reg; i_next = i_reg + 1'b1;
                        state_next = S_SCNR;
                    end
                    else
                    begin
                        s_next = s_reg - 1'b1;
                        b_next = piv_reg;
                        raddr = IDX_W'(s_reg - 2'd3);
                        ph_next = 2'd1;
                        state_next = S_SCNM;
                    end
                end
                else
                begin
                    we = 1'b1; waddr = s_reg[IDX_W-1:0]; wdata = t_reg;
                    piv_next = b_reg; b_next = t_reg;
                    s_next = s_reg + 1'b1; i_next = i_reg + 1'b1;
                    state_next = S_SCNR;
                end
            end
            S_OUTR:
            begin
                raddr = i_reg[IDX_W-1:0];
                if (!ovalid_reg || m_tready)
                begin
                    state_next = S_OUTW;
                end
            end
            S_OUTW:
            begin
                ovalid_next = 1'b1; opt_next = rdata;
                olast_next = (i_reg + 1'b1 == s_reg);
                i_next = i_reg + 1'b1;
                if (i_reg + 1'b1 == s_reg)
                begin
                    n_next = '0;
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_OUTR;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
        if (state_reg == S_LOAD && ovalid_reg && m_tready && olast_reg)
        begin
            ovf_next = 1'b0;
        end
    end

    // In the scan the stack top sits in b_reg, the entry below it in piv_reg
    // and the new point in a_reg, so the sort datapath computes the turn test.
    always_ff @(posedge clk)
    begin
        piv_reg <= piv_next;
        t_reg <= t_next;
        opt_reg <= opt_next;
        a_reg <= a_next;
        b_reg <= b_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            n_reg <= '0; i_reg <= '0; j_reg <= '0; s_reg <= '0; best_reg <= '0;
            ovf_reg <= 1'b0; mul_sel_reg <= 1'b0; psel_reg <= 1'b0; ph_reg <= '0;
            ovalid_reg <= 1'b0; olast_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg <= n_next; i_reg <= i_next; j_reg <= j_next; s_reg <= s_next;
            best_reg <= best_next; ovf_reg <= ovf_next;
            mul_sel_reg <= mul_sel_next;
            psel_reg <= mul_sel_reg;
            ph_reg <= ph_next;
            ovalid_reg <= ovalid_next; olast_reg <= olast_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCNR |-> s_reg <= i_reg) else $error("stack beyond points");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !m_tready |=> ovalid_reg) else $error("result dropped");
`endif
endmodule

@@ rtl/convex_hull_graham_scan_core.sv @@
// Top level of the Graham scan convex hull core.
// Depends on chgs_pkg, chgs_front, chgs_back (and chgs_ram inside it).
//
//   channel   direction  tdata (low bit up)          tuser / tlast
//   s_axis    in         px[30:0], py[61:31], pad    tlast = last
//   m_axis    out        hx[30:0], hy[61:31], pad    tuser = final_vertex, overflowed
//
// Points are loaded into the store one at a time. A set of n points then
// passes the pivot search, the pivot swap, the insertion sort (up to
// (n-1)*(n-2)/2 comparisons), the scan with its turn tests and pops, and
// the output, which emits one result at a time. Reset is asynchronous,
// active low. Input stalls once the two-entry queue is full while the
// back part computes or holds its last result.
`timescale 1ns / 1ps
module convex_hull_graham_scan_core
    import chgs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // px, py, zero pad
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // hx, hy, zero pad
    output logic [1:0]  m_tuser,  // final_vertex, overflowed
    output logic        m_tlast
);
    logic q_valid, q_ready;
    cmd_t q_cmd;

    chgs_front u_front (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tlast(s_tlast),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd));

    chgs_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_cmd(q_cmd), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast));
endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the Graham scan convex hull core.
// Needs chgs_pkg and convex_hull_graham_scan_core; hull sets are predicted locally.
`timescale 1ns / 1ps
module testbench;
    import chgs_pkg::*;

    localparam int LO = -1073741824;
    localparam int HI = 1073741823;
    localparam int STALL_LIMIT = 200000;

    typedef struct {
        bit signed [COORD_W-1:0] x;
        bit signed [COORD_W-1:0] y;
        bit                      fin;
        bit                      ovf;
    } vertex_t;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    convex_hull_graham_scan_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Points of the set being loaded, as the block should hold them.
    longint  set_x[MAX_POINTS];
    longint  set_y[MAX_POINTS];
    int      set_count = 0;
    bit      set_dropped = 0;
    vertex_t hull_queue[$];

    int  errors = 0;
    int  points_sent = 0;
    int  sets_sent = 0;
    int  vertices_seen = 0;
    int  hold_left = 0;
    bit  no_idle = 0;
    int  quiet_cycles = 0;

    function automatic longint cross_at(longint ox, longint oy, longint ax, longint ay,
                                        longint bx, longint by);
        return (ox - ax) * (oy - by) - (oy - ay) * (ox - bx);
    endfunction

    function automatic longint dist_sq(longint ox, longint oy, longint ax, longint ay);
        return (ox - ax) * (ox - ax) + (oy - ay) * (oy - ay);
    endfunction

    // Angular order about the pivot; collinear points go nearest first.
    function automatic bit goes_first(int a, int b);
        longint c;
        c = cross_at(set_x[b], set_y[b], set_x[0], set_y[0], set_x[a], set_y[a]);
        if (c != 0)
            return c > 0;
        return dist_sq(set_x[0], set_y[0], set_x[a], set_y[a]) <
               dist_sq(set_x[0], set_y[0], set_x[b], set_y[b]);
    endfunction

    task automatic predict_hull();
        int     best, j, s;
        longint tx, ty;
        vertex_t v;
        best = 0;
        s = 0;
        if (set_count > 1) begin
            for (int i = 1; i < set_count; i++)
                if (set_x[i] < set_x[best] || (set_x[i] == set_x[best] && set_y[i] > set_y[best]))
                    best = i;
            tx = set_x[0]; ty = set_y[0];
            set_x[0] = set_x[best]; set_y[0] = set_y[best];
            set_x[best] = tx; set_y[best] = ty;
            for (int i = 2; i < set_count; i++) begin
                tx = set_x[i]; ty = set_y[i];
                j = i;
                while (j > 1) begin
                    set_x[j] = tx; set_y[j] = ty;
                    if (!goes_first(j, j - 1))
                        break;
                    set_x[j] = set_x[j-1]; set_y[j] = set_y[j-1];
                    j--;
                end
                set_x[j] = tx; set_y[j] = ty;
            end
            for (int i = 0; i < set_count; i++) begin
                tx = set_x[i]; ty = set_y[i];
                if (s > 0 && set_x[s-1] == tx && set_y[s-1] == ty)
                    continue;
                while (s >= 2 && cross_at(set_x[s-1], set_y[s-1], set_x[s-2], set_y[s-2],
                                          tx, ty) >= 0)
                    s--;
                set_x[s] = tx; set_y[s] = ty;
                s++;
            end
        end else begin
            s = set_count;
        end
        for (int k = 0; k < s; k++) begin
            v.x = set_x[k][COORD_W-1:0];
            v.y = set_y[k][COORD_W-1:0];
            v.fin = (k + 1 == s);
            v.ovf = set_dropped;
            hull_queue = {hull_queue, v};
        end
        set_count = 0;
        set_dropped = 0;
    endtask

    // Offers one point after a random gap (none while no_idle is set) and waits until it is taken.
    task automatic send_point(int x, int y, bit last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            @(negedge clk);
            s_tvalid = 0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1;
        s_tdata = {2'b00, y[COORD_W-1:0], x[COORD_W-1:0]};
        s_tlast = last;
        do @(posedge clk); while (!s_tready);
        if (set_count < MAX_POINTS) begin
            set_x[set_count] = x;
            set_y[set_count] = y;
            set_count++;
        end else begin
            set_dropped = 1;
        end
        points_sent++;
        if (last) begin
            sets_sent++;
            predict_hull();
        end
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_tvalid = 0;
        s_tlast = 0;
    endtask

    task automatic wait_drained();
        stop_sending();
        wait (hull_queue.size() == 0);
        repeat (20) @(negedge clk);
    endtask

    // Random set; style 0 spans the full range, 1 a tiny grid with repeats,
    // 2 a single line, 3 the corners of the range mixed with grid points.
    task automatic send_random_set(int n, int style);
        int x, y, dx, dy, x0, y0;
        x0 = $urandom_range(0, 200) - 100;
        y0 = $urandom_range(0, 200) - 100;
        dx = $urandom_range(0, 6) - 3;
        dy = $urandom_range(0, 6) - 3;
        for (int i = 0; i < n; i++) begin
            case (style)
                0: begin x = $urandom; y = $urandom; x = x >>> 1; y = y >>> 1; end
                1: begin x = $urandom_range(0, 8) - 4; y = $urandom_range(0, 8) - 4; end
                2: begin
                    x = x0 + dx * ($urandom_range(0, 20) - 10);
                    y = y0 + dy * ($urandom_range(0, 20) - 10);
                end
                default: begin
                    x = $urandom_range(0, 1) ? HI : LO;
                    y = $urandom_range(0, 1) ? HI : LO;
                    if ($urandom_range(0, 2) == 0) begin
                        x = $urandom_range(0, 8) - 4;
                        y = $urandom_range(0, 8) - 4;
                    end
                end
            endcase
            send_point(x, y, i == n - 1);
        end
    endtask

    task automatic test_special_sets();
        send_point(7, -3, 1);                 // single point
        send_point(5, 5, 0); send_point(5, 5, 0); send_point(5, 5, 1);
        send_point(0, 0, 0); send_point(2, 2, 0); send_point(1, 1, 0);
        send_point(3, 3, 1);                  // collinear
        send_point(0, 0, 0); send_point(4, 0, 0); send_point(4, 4, 0);
        send_point(0, 4, 0); send_point(2, 2, 0); send_point(2, 0, 1);
        send_point(1, 0, 0); send_point(1, 5, 0); send_point(3, 2, 1); // pivot tie on x
    endtask

    task automatic test_extremes();
        send_point(LO, LO, 0); send_point(HI, LO, 0); send_point(HI, HI, 0);
        send_point(LO, HI, 0); send_point(0, 0, 0); send_point(-1, 1, 1);
        wait_drained();
    endtask

    task automatic test_full_and_overflow();
        send_random_set(MAX_POINTS + 6, 0);  // last mark falls on a dropped point
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_left = 3000;
        no_idle = 1;
        repeat (3) send_random_set(8, 0);
        no_idle = 0;
        wait_drained();
    endtask

    task automatic test_random_sets();
        int n;
        for (int k = 0; k < 8; k++) begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(3, 10);
            send_random_set(n, $urandom_range(0, 3));
            if (k % 4 == 3)
                no_idle = ~no_idle;
        end
        no_idle = 0;
        wait_drained();
    endtask

    // Result side: random stalls, a forced hold-off, and the field checks.
    initial begin
        int stall;
        vertex_t want;
        bit signed [COORD_W-1:0] gx, gy;
        stall = 0;
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready) begin
                vertices_seen++;
                gx = m_tdata[COORD_W-1:0];
                gy = m_tdata[2*COORD_W-1:COORD_W];
                if (hull_queue.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected vertex (%0d, %0d)", gx, gy);
                end else begin
                    want = hull_queue.pop_front();
                    if (gx !== want.x || gy !== want.y || m_tuser[0] !== want.fin ||
                        m_tuser[1] !== want.ovf || m_tlast !== want.fin || m_tdata[63:62] !== 0) begin
                        errors++;
                        if (errors <= 10)
                            $display("vertex mismatch: expected (%0d, %0d) fin %0b ovf %0b, got (%0d, %0d) user %b last %b",
                                     want.x, want.y, want.fin, want.ovf, gx, gy, m_tuser, m_tlast);
                    end
                end
                stall = no_idle ? 0 : $urandom_range(0, 15);
            end
            @(negedge clk);
            if (hold_left > 0) begin
                m_tready = 0;
                hold_left--;
            end else if (stall > 0) begin
                m_tready = 0;
                stall--;
            end else begin
                m_tready = 1;
            end
        end
    end

    // Watchdog on cycles with no accepted item on either side.
    initial begin
        forever begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(negedge clk);
        rst_n = 1;
        test_special_sets();
        test_extremes();
        test_full_and_overflow();
        test_backpressure();
        test_random_sets();
        if (hull_queue.size() != 0)
            errors++;
        $display("Sent %0d points in %0d sets; checked %0d hull vertices.",
                 points_sent, sets_sent, vertices_seen);
        $display("Covered single, repeated, collinear, extreme, full and overflowing sets.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
